// File: design/bci_pkg.sv
`default_nettype none
package bci_pkg;

   localparam int MaxPointsDefault = 64;
   localparam int TickWidth        = 32;
   localparam int AmountWidth      = 17;
   localparam int StatusWidth      = 2;
   localparam int CountOutWidth    = 7;
   localparam int NumWidth         = 50;
   localparam int DenWidth         = 33;

   localparam logic [AmountWidth-1:0] AmountOne = 17'd65536;

   localparam logic [1:0] CmdUpsert   = 2'd0;
   localparam logic [1:0] CmdErase    = 2'd1;
   localparam logic [1:0] CmdEvaluate = 2'd2;

   localparam logic [1:0] StatusOk       = 2'd0;
   localparam logic [1:0] StatusInvalid  = 2'd1;
   localparam logic [1:0] StatusFull     = 2'd2;
   localparam logic [1:0] StatusNotFound = 2'd3;

   // Division request from the sequencer to the divider.
   typedef struct packed {
      logic                start;
      logic [NumWidth-1:0] dividend;
      logic [DenWidth-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic                done;
      logic [NumWidth-1:0] quotient;
   } div_rsp_type;

endpackage
`default_nettype wire

// File: design/bci_divider.sv
`default_nettype none
module bci_divider (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire bci_pkg::div_req_type div_req,
   output bci_pkg::div_rsp_type      div_rsp
);
   import bci_pkg::*;

   localparam int StepWidth = $clog2(NumWidth + 1);

   logic [NumWidth-1:0]  quot_ff, quot_in;
   logic [DenWidth:0]    rem_ff, rem_in;
   logic [DenWidth-1:0]  den_ff, den_in;
   logic [StepWidth-1:0] step_ff, step_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DenWidth:0]    trial;

   // One restoring division step per cycle, dividend bits shifted in from the top.
   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[DenWidth-1:0], quot_ff[NumWidth-1]};
      if (div_req.start) begin
         quot_in = div_req.dividend;
         rem_in  = '0;
         den_in  = div_req.divisor;
         step_in = StepWidth'(NumWidth);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in  = trial - {1'b0, den_ff};
            quot_in = {quot_ff[NumWidth-2:0], 1'b1};
         end else begin
            rem_in  = trial;
            quot_in = {quot_ff[NumWidth-2:0], 1'b0};
         end
         step_in = step_ff - 1'b1;
         if (step_ff == StepWidth'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      step_ff <= step_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quot_ff;

   // The unit never reports done while still iterating.
   assert property (@(posedge clock) disable iff (reset) done_ff |-> !busy_ff)
      else $error("divider done while busy");
   // A result is flagged in the cycle after the last step.
   assert property (@(posedge clock) disable iff (reset)
      (busy_ff && step_ff == StepWidth'(1) && !div_req.start) |=> done_ff)
      else $error("divider missed done");
   assert property (@(posedge clock) disable iff (reset) busy_ff |-> step_ff != '0)
      else $error("divider step count underflow");

endmodule
`default_nettype wire

// File: design/breakpoint_curve_interpolator.sv
`default_nettype none
// Channel  Direction  tdata (low bit up)                                 tuser
// req      in         key_tick[31:0], entry_amount[48:32]                cmd[1:0]
// rsp      out        status[1:0], curve_value[18:2], point_count[25:19] -
//
// One item at a time. The table lives in a memory with one read port and one
// write port, read once per cycle. A search visits one entry per cycle and an
// erase shift moves one entry per cycle; an insert shift reads and then writes
// each entry in separate steps. An evaluate also runs the 50-step serial
// divider. Reset clears only the state and the point count. A stalled result
// holds the block; req_tready is low from acceptance until the result beat is
// taken.
module breakpoint_curve_interpolator #(
   parameter int MAX_POINTS = bci_pkg::MaxPointsDefault
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [55:0] req_tdata,   // key_tick, entry_amount
   input  wire logic [1:0]  req_tuser,   // cmd
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata    // status, curve_value, point_count
);
   import bci_pkg::*;

   localparam int IdxWidth = $clog2(MAX_POINTS);
   localparam int CntWidth = $clog2(MAX_POINTS + 1);

   localparam logic [3:0] StIdle   = 4'd0;
   localparam logic [3:0] StSearch = 4'd1;
   localparam logic [3:0] StDecide = 4'd2;
   localparam logic [3:0] StShUp   = 4'd3;
   localparam logic [3:0] StShDn   = 4'd4;
   localparam logic [3:0] StLoadB  = 4'd5;
   localparam logic [3:0] StMul    = 4'd6;
   localparam logic [3:0] StDiv    = 4'd7;
   localparam logic [3:0] StOut    = 4'd8;
   localparam logic [3:0] StWrite  = 4'd9;

   // Table memory: tick and amount side by side.
   logic [TickWidth+AmountWidth-1:0] mem [MAX_POINTS];
   logic [TickWidth+AmountWidth-1:0] rd_ff;
   logic [IdxWidth-1:0]              raddr;
   logic                             we;
   logic [IdxWidth-1:0]              waddr;
   logic [TickWidth+AmountWidth-1:0] wdata;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rd_ff <= mem[raddr];
   end

   logic [3:0]                   state_ff, state_in;
   logic [CntWidth-1:0]          count_ff, count_in;
   logic [CntWidth-1:0]          idx_ff, idx_in;
   logic [1:0]                   cmd_ff, cmd_in;
   logic signed [TickWidth-1:0]  tick_ff, tick_in;
   logic [AmountWidth-1:0]       amt_ff, amt_in;
   logic [1:0]                   status_ff, status_in;
   logic [AmountWidth-1:0]       value_ff, value_in;
   logic [TickWidth+AmountWidth-1:0] prev_ff, prev_in;
   logic [NumWidth-1:0]          num_ff, num_in;
   logic [DenWidth-1:0]          den_ff, den_in;
   logic                         mulsel_ff, mulsel_in;
   div_req_type                  div_req;
   div_rsp_type                  div_rsp;

   logic signed [TickWidth-1:0]  rd_tick, prev_tick;
   logic [AmountWidth-1:0]       rd_amt, prev_amt;
   logic signed [TickWidth:0]    off_s;
   logic signed [AmountWidth:0]  da_s;
   logic signed [NumWidth:0]     prod;

   assign rd_tick   = rd_ff[TickWidth+AmountWidth-1:AmountWidth];
   assign rd_amt    = rd_ff[AmountWidth-1:0];
   assign prev_tick = prev_ff[TickWidth+AmountWidth-1:AmountWidth];
   assign prev_amt  = prev_ff[AmountWidth-1:0];
   assign off_s     = {tick_ff[TickWidth-1], tick_ff} - {prev_tick[TickWidth-1], prev_tick};
   assign da_s      = {1'b0, rd_amt} - {1'b0, prev_amt};

   bci_divider u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // Sequencer: linear scan, then shift or write, or product sum and divide.
   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      idx_in     = idx_ff;
      cmd_in     = cmd_ff;
      tick_in    = tick_ff;
      amt_in     = amt_ff;
      status_in  = status_ff;
      value_in   = value_ff;
      prev_in    = prev_ff;
      num_in     = num_ff;
      den_in     = den_ff;
      mulsel_in  = mulsel_ff;
      raddr      = idx_ff[IdxWidth-1:0];
      we         = 1'b0;
      waddr      = idx_ff[IdxWidth-1:0];
      wdata      = {tick_ff, amt_ff};
      div_req    = '0;
      prod       = '0;
      case (state_ff)
         StIdle: begin
            if (req_tvalid) begin
               cmd_in    = req_tuser;
               tick_in   = req_tdata[31:0];
               amt_in    = req_tdata[48:32];
               status_in = StatusOk;
               value_in  = '0;
               idx_in    = '0;
               raddr     = '0;
               if (req_tuser == CmdUpsert
                   && (req_tdata[31] || req_tdata[48:32] > AmountOne)) begin
                  status_in = StatusInvalid;
                  state_in  = StOut;
               end else if (req_tuser != CmdUpsert && req_tuser != CmdErase
                            && req_tuser != CmdEvaluate) begin
                  status_in = StatusInvalid;
                  state_in  = StOut;
               end else if (count_ff == '0) begin
                  status_in = (req_tuser == CmdErase) ? StatusNotFound : StatusOk;
                  state_in  = (req_tuser == CmdUpsert) ? StWrite : StOut;
               end else begin
                  state_in = StSearch;
               end
            end
         end
         StSearch: begin
            // rd_ff = entry idx_ff; stop at tick >= key (eval: > key past idx 0).
            if (cmd_ff == CmdEvaluate) begin
               if (idx_ff == '0 && tick_ff <= rd_tick) begin
                  value_in = rd_amt;
                  state_in = StOut;
               end else if (rd_tick > tick_ff) begin
                  state_in = StLoadB;
               end else if (idx_ff == count_ff - 1'b1) begin
                  value_in = rd_amt;
                  state_in = StOut;
               end else begin
                  prev_in    = rd_ff;
                  idx_in     = idx_ff + 1'b1;
                  raddr      = idx_in[IdxWidth-1:0];
               end
            end else if (rd_tick >= tick_ff) begin
               state_in = StDecide;
            end else if (idx_ff == count_ff - 1'b1) begin
               idx_in   = count_ff;
               state_in = StDecide;
            end else begin
               idx_in     = idx_ff + 1'b1;
               raddr      = idx_in[IdxWidth-1:0];
            end
         end
         StDecide: begin
            // idx is the lower index; rd_ff valid when idx < count.
            if (idx_ff < count_ff && rd_tick == tick_ff) begin
               if (cmd_ff == CmdUpsert) begin
                  state_in = StWrite;
               end else if (idx_ff == count_ff - 1'b1) begin
                  count_in = count_ff - 1'b1;
                  state_in = StOut;
               end else begin
                  idx_in     = idx_ff + 1'b1;
                  raddr      = idx_in[IdxWidth-1:0];
                  state_in   = StShDn;
               end
            end else if (cmd_ff == CmdErase) begin
               status_in = StatusNotFound;
               state_in  = StOut;
            end else if (count_ff == CntWidth'(MAX_POINTS)) begin
               status_in = StatusFull;
               state_in  = StOut;
            end else begin
               amt_in     = amt_ff;
               prev_in    = {tick_ff, amt_ff};
               idx_in     = idx_ff;
               mulsel_in  = 1'b0;
               state_in   = (idx_ff == count_ff) ? StWrite : StShUp;
               count_in   = (idx_ff == count_ff) ? count_ff + 1'b1 : count_ff;
               raddr      = idx_ff[IdxWidth-1:0];
            end
         end
         StShUp: begin
            // Ripple insert: write carried entry at idx, carry the displaced one.
            if (!mulsel_ff) begin
               mulsel_in = 1'b1;
            end else begin
               we      = 1'b1;
               wdata   = prev_ff;
               prev_in = rd_ff;
               idx_in  = idx_ff + 1'b1;
               raddr   = idx_in[IdxWidth-1:0];
               mulsel_in = 1'b0;
               if (idx_ff == count_ff) begin
                  count_in = count_ff + 1'b1;
                  state_in = StOut;
               end
            end
         end
         StShDn: begin
            // rd_ff is entry idx; move it down one place.
            we    = 1'b1;
            waddr = IdxWidth'(idx_ff - 1'b1);
            wdata = rd_ff;
            if (idx_ff == count_ff - 1'b1) begin
               count_in = count_ff - 1'b1;
               state_in = StOut;
            end else begin
               idx_in = idx_ff + 1'b1;
               raddr  = idx_in[IdxWidth-1:0];
            end
         end
         StLoadB: begin
            // Denominator d and first partial product a0*d.
            den_in    = DenWidth'({rd_tick[TickWidth-1], rd_tick}
                                  - {prev_tick[TickWidth-1], prev_tick});
            prod      = $signed({1'b0, prev_amt}) * $signed(den_in);
            num_in    = NumWidth'(prod);
            state_in  = StMul;
         end
         StMul: begin
            prod   = $signed(da_s) * $signed(off_s);
            num_in = NumWidth'($signed({1'b0, num_ff}) + prod);
            if ($signed({1'b0, num_ff}) + prod < 0) begin
               num_in = '0;
            end
            state_in = StDiv;
            div_req.start    = 1'b1;
            div_req.dividend = {num_in[NumWidth-2:0], 1'b0} + NumWidth'(den_ff);
            div_req.divisor  = {den_ff[DenWidth-2:0], 1'b0};
         end
         StDiv: begin
            if (div_rsp.done) begin
               value_in = (div_rsp.quotient > NumWidth'(AmountOne))
                          ? AmountOne : div_rsp.quotient[AmountWidth-1:0];
               state_in = StOut;
            end
         end
         StWrite: begin
            we    = 1'b1;
            wdata = {tick_ff, amt_ff};
            if (count_ff == '0) begin
               waddr    = '0;
               count_in = CntWidth'(1);
            end
            state_in = StOut;
         end
         StOut: begin
            if (rsp_tready) begin
               state_in = StIdle;
            end
         end
         default: state_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      cmd_ff     <= cmd_in;
      tick_ff    <= tick_in;
      amt_ff     <= amt_in;
      status_ff  <= status_in;
      value_ff   <= value_in;
      prev_ff    <= prev_in;
      num_ff     <= num_in;
      den_ff     <= den_in;
      mulsel_ff  <= mulsel_in;
      if (reset) begin
         state_ff   <= StIdle;
         count_ff   <= '0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
      end
   end

   assign req_tready = (state_ff == StIdle);
   assign rsp_tvalid = (state_ff == StOut);
   assign rsp_tdata  = {6'd0, CountOutWidth'(count_ff), value_ff, status_ff};

   assert property (@(posedge clock) disable iff (reset) count_ff <= CntWidth'(MAX_POINTS))
      else $error("point count above capacity");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == StIdle) |=> $stable(count_ff))
      else $error("count moved while idle");
   assert property (@(posedge clock) disable iff (reset) !(req_tready && rsp_tvalid))
      else $error("accepting while a result is pending");
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && value_ff != '0) |-> cmd_ff == CmdEvaluate)
      else $error("value on a non-evaluate result");

endmodule
`default_nettype wire
